### src/amb_pkg.sv
`timescale 1ns / 1ps
// Package for the multi-alarm matcher: slot count, action and register codes,
// reset values and the slot entry and control structs. Depends on nothing.
package amb_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_ADD   = 2'd2;

    localparam logic [1:0] REG_BEEP_ON     = 2'd0;
    localparam logic [1:0] REG_BEEP_OFF    = 2'd1;
    localparam logic [1:0] REG_DEF_HOUR    = 2'd2;
    localparam logic [1:0] REG_DEF_MINUTE  = 2'd3;

    localparam logic [15:0] BEEP_MS_RESET      = 16'd500;
    localparam logic [4:0]  DEF_HOUR_RESET     = 5'd7;
    localparam logic [5:0]  DEF_MINUTE_RESET   = 6'd0;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       enabled;
        logic       fired;
    } amb_entry_t;

    typedef struct packed {
        logic             we;
        logic [SlotW-1:0] idx;
        amb_entry_t       data;
    } amb_wr_t;

    typedef struct packed {
        logic ring_set;
        logic step;
        logic stop;
    } amb_beep_ctrl_t;

endpackage

### src/amb_slot_table.sv
`timescale 1ns / 1ps
// Alarm slot table: one entry per slot, one write port and one read port.
// Depends on amb_pkg.
module amb_slot_table (
    input  logic               clk,
    input  logic               rst_n,
    input  amb_pkg::amb_wr_t   wr,
    input  logic [amb_pkg::SlotW-1:0] rd_idx,
    output amb_pkg::amb_entry_t rd_data
);
    import amb_pkg::*;

    amb_entry_t entry_reg [SLOT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (wr.we)
        begin
            entry_reg[wr.idx] <= wr.data;
        end
    end

    assign rd_data = entry_reg[rd_idx];

endmodule

### src/amb_beeper.sv
`timescale 1ns / 1ps
// Ringing flag and buzzer phase timer with its shared subtract and compare.
// Depends on amb_pkg.
module amb_beeper (
    input  logic                    clk,
    input  logic                    rst_n,
    input  amb_pkg::amb_beep_ctrl_t ctrl,
    input  logic [31:0]             now_ms,
    input  logic [15:0]             beep_on_ms,
    input  logic [15:0]             beep_off_ms,
    output logic                    ring_active,
    output logic                    buzzer_level
);
    import amb_pkg::*;

    logic        ring_reg, ring_next;
    logic        buzz_reg, buzz_next;
    logic [31:0] last_reg, last_next;
    logic [31:0] elapsed;
    logic [15:0] span;

    assign elapsed = now_ms - last_reg;
    assign span = buzz_reg ? beep_on_ms : beep_off_ms;

    always_comb
    begin
        ring_next = ring_reg;
        buzz_next = buzz_reg;
        last_next = last_reg;
        if (ctrl.ring_set)
        begin
            ring_next = 1'b1;
        end
        if (ctrl.step && ring_reg)
        begin
            if (ctrl.stop)
            begin
                ring_next = 1'b0;
                buzz_next = 1'b0;
            end
            else if (elapsed >= {16'd0, span})
            begin
                buzz_next = !buzz_reg;
                last_next = now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= 1'b0;
            buzz_reg <= 1'b0;
            last_reg <= '0;
        end
        else
        begin
            ring_reg <= ring_next;
            buzz_reg <= buzz_next;
            last_reg <= last_next;
        end
    end

    assign ring_active = ring_reg;
    assign buzzer_level = buzz_reg;

endmodule

### src/multi_alarm_matcher_with_beeper.sv
`timescale 1ns / 1ps
// Multi-alarm matcher with beeper: sequencer, configuration registers and
// result register. Depends on amb_pkg, amb_slot_table and amb_beeper.
//
// Usage: the input channel (in_valid, in_stall) carries one word per action:
// a tick, a slot write or an add. Each accepted word yields exactly one
// result word on the output channel (out_valid, out_stall).
// The sequencer visits the slots one per cycle through the single table
// read port. A tick runs a slot scan over all slots, a buzzer timing step
// and a result load, in that order. An add scans the slots and stops at
// the first disabled slot. A write writes its slot before the result
// load, and an unused action goes straight to the result load.
// One word is in work at a time; in_stall is high from acceptance until
// the result has been loaded into the output register.
// A result that waits under out_stall holds the output register; the next
// input word is still taken and worked on, and its result waits until the
// output register is free.
// Reset clears all slots to disabled, silences the buzzer and loads the
// configuration registers with their defaults. Configuration writes
// through cfg_we, cfg_index and cfg_data are taken at any cycle.
module multi_alarm_matcher_with_beeper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] now_ms,
    input  logic [4:0]  hour_now,
    input  logic [5:0]  minute_now,
    input  logic        stop_pressed,
    input  logic [2:0]  slot_index,
    input  logic [4:0]  slot_hour,
    input  logic [5:0]  slot_minute,
    input  logic        slot_enable,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        buzzer_on,
    output logic        ringing,
    output logic        slot_found,
    output logic [2:0]  slot_given
);
    import amb_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_BEEP  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [SlotW-1:0] LastIdx = SlotW'(SLOT_COUNT - 1);
    localparam logic [SlotW+2:0] SlotLimit = (SlotW + 3)'(SLOT_COUNT);

    logic [2:0]       state_reg, state_next;
    logic [SlotW-1:0] idx_reg, idx_next;
    logic             found_reg, found_next;
    logic [SlotW-1:0] given_reg, given_next;

    logic [15:0] beep_on_reg, beep_off_reg;
    logic [4:0]  def_hour_reg;
    logic [5:0]  def_minute_reg;

    logic [1:0]  act_reg;
    logic [31:0] now_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic        stop_reg;
    logic [2:0]  widx_reg;
    logic [4:0]  whour_reg;
    logic [5:0]  wminute_reg;
    logic        wen_reg;

    logic        outv_reg;
    logic        obuzz_reg, oring_reg, ofound_reg;
    logic [2:0]  ogiven_reg;

    amb_wr_t        tbl_wr;
    amb_entry_t     rd_entry;
    amb_beep_ctrl_t bctrl;
    logic           ring_active, buzzer_level;
    logic           accept, load_out, hit;
    logic [SlotW+2:0] widx_wide;
    logic [SlotW+2:0] given_wide;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!outv_reg || !out_stall);
    assign hit = (rd_entry.hour == hour_reg) && (rd_entry.minute == minute_reg);
    assign widx_wide = {{SlotW{1'b0}}, widx_reg};
    assign given_wide = {3'b000, given_reg};

    amb_slot_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .rd_idx  (idx_reg),
        .rd_data (rd_entry)
    );

    amb_beeper u_beeper (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (bctrl),
        .now_ms       (now_reg),
        .beep_on_ms   (beep_on_reg),
        .beep_off_ms  (beep_off_reg),
        .ring_active  (ring_active),
        .buzzer_level (buzzer_level)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        found_next = found_reg;
        given_next = given_reg;
        tbl_wr = '0;
        tbl_wr.idx = idx_reg;
        tbl_wr.data = rd_entry;
        bctrl = '0;
        bctrl.stop = stop_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    found_next = 1'b0;
                    given_next = '0;
                    case (action)
                        ACT_TICK, ACT_ADD: state_next = ST_SCAN;
                        ACT_WRITE:         state_next = ST_WRITE;
                        default:           state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (act_reg == ACT_TICK)
                begin
                    if (rd_entry.enabled)
                    begin
                        tbl_wr.we = 1'b1;
                        tbl_wr.data.fired = hit;
                        bctrl.ring_set = hit && !rd_entry.fired;
                    end
                    if (idx_reg == LastIdx)
                    begin
                        state_next = ST_BEEP;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (!rd_entry.enabled)
                    begin
                        tbl_wr.we = 1'b1;
                        tbl_wr.data.hour = def_hour_reg;
                        tbl_wr.data.minute = def_minute_reg;
                        tbl_wr.data.enabled = 1'b1;
                        tbl_wr.data.fired = 1'b0;
                        found_next = 1'b1;
                        given_next = idx_reg;
                        state_next = ST_DONE;
                    end
                    else if (idx_reg == LastIdx)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_WRITE:
            begin
                tbl_wr.we = (widx_wide < SlotLimit);
                tbl_wr.idx = widx_wide[SlotW-1:0];
                tbl_wr.data.hour = whour_reg;
                tbl_wr.data.minute = wminute_reg;
                tbl_wr.data.enabled = wen_reg;
                tbl_wr.data.fired = 1'b0;
                state_next = ST_DONE;
            end
            ST_BEEP:
            begin
                bctrl.step = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            found_reg <= 1'b0;
            given_reg <= '0;
            outv_reg <= 1'b0;
            beep_on_reg <= BEEP_MS_RESET;
            beep_off_reg <= BEEP_MS_RESET;
            def_hour_reg <= DEF_HOUR_RESET;
            def_minute_reg <= DEF_MINUTE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            found_reg <= found_next;
            given_reg <= given_next;
            if (load_out)
            begin
                outv_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                outv_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BEEP_ON:    beep_on_reg <= cfg_data;
                    REG_BEEP_OFF:   beep_off_reg <= cfg_data;
                    REG_DEF_HOUR:   def_hour_reg <= cfg_data[4:0];
                    REG_DEF_MINUTE: def_minute_reg <= cfg_data[5:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            now_reg <= now_ms;
            hour_reg <= hour_now;
            minute_reg <= minute_now;
            stop_reg <= stop_pressed;
            widx_reg <= slot_index;
            whour_reg <= slot_hour;
            wminute_reg <= slot_minute;
            wen_reg <= slot_enable;
        end
        if (load_out)
        begin
            obuzz_reg <= buzzer_level;
            oring_reg <= ring_active;
            ofound_reg <= found_reg;
            ogiven_reg <= given_wide[2:0];
        end
    end

    assign out_valid = outv_reg;
    assign buzzer_on = obuzz_reg;
    assign ringing = oring_reg;
    assign slot_found = ofound_reg;
    assign slot_given = ogiven_reg;

`ifndef ASSERT_OFF
    a_buzz_needs_ring: assert property (@(posedge clk) disable iff (!rst_n)
        !ring_active |-> !buzzer_level)
        else $error("buzzer on while not ringing");

    a_table_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.we |-> (state_reg != ST_IDLE))
        else $error("slot table written while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("sequencer did not start after acceptance");

    a_found_only_add: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && state_reg == ST_DONE) |-> (act_reg == ACT_ADD))
        else $error("slot found reported for a non-add action");
`endif

endmodule
